/* hdl/wideband_lambda_control_tick_macros.svh */
// assertion macros for the wideband lambda control tick block
// no dependencies; taken in by the files that carry assertions
`ifndef WIDEBAND_LAMBDA_CONTROL_TICK_MACROS_SVH
`define WIDEBAND_LAMBDA_CONTROL_TICK_MACROS_SVH

`ifndef SYNTH

// plain property, checked out of reset
`define WLCT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("wlct assertion failed");

// implication: ante on an edge requires cons on the same edge
`define WLCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wlct implication failed");

`else

`define WLCT_ASSERT(lbl, clk, rst_n, prop)
`define WLCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* hdl/wlct_pkg.sv */
// shared types and constants of the wideband lambda control tick block
// no dependencies; used by the top level, the table and the divider
package wlct_pkg;

  localparam int TABLE_POINTS = 16;
  localparam int TBL_AW       = $clog2(TABLE_POINTS);

  localparam logic [15:0] LAMBDA_ONE = 16'd4096;
  localparam logic [9:0]  PUMP_PUSH  = 10'd650;
  localparam logic [9:0]  PUMP_PULL  = 10'd350;
  localparam logic [9:0]  HEAT_ON    = 10'd800;
  localparam logic [9:0]  HEAT_OFF   = 10'd0;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_NERNST_TARGET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEATER_TARGET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEATER_INTVL  = 3'd4;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // divider geometry
  localparam int DIV_N_W   = 32;
  localparam int DIV_D_W   = 16;
  localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_CLAMP,
    ST_LOW,
    ST_HIGH,
    ST_SCAN,
    ST_MUL,
    ST_DIVGO,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic [15:0]        y;
  } tbl_entry_t;

  typedef struct packed {
    logic              we;
    logic [TBL_AW-1:0] addr;
    tbl_entry_t        entry;
  } tbl_wr_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* hdl/wlct_stream_if.sv */
// valid/ready channel interfaces for transactions into and out of the block
// depends on nothing; used by the top level
interface wlct_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [11:0]        vgnd_raw;
  logic [11:0]        nernst_raw;
  logic [11:0]        pump_raw;
  logic [11:0]        pulse_low_raw;
  logic [11:0]        pulse_high_raw;
  logic [3:0]         point_index;
  logic signed [15:0] point_current;
  logic [15:0]        point_lambda;

  modport source (output valid, operation, vgnd_raw, nernst_raw, pump_raw,
                  pulse_low_raw, pulse_high_raw, point_index, point_current,
                  point_lambda, input ready);
  modport sink (input valid, operation, vgnd_raw, nernst_raw, pump_raw,
                pulse_low_raw, pulse_high_raw, point_index, point_current,
                point_lambda, output ready);
endinterface

interface wlct_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  pump_duty;
  logic [9:0]  heater_duty;
  logic [15:0] lambda_value;
  logic        heater_evaluated;

  modport source (output valid, pump_duty, heater_duty, lambda_value,
                  heater_evaluated, input ready);
  modport sink (input valid, pump_duty, heater_duty, lambda_value,
                heater_evaluated, output ready);
endinterface

/* hdl/wideband_lambda_control_tick.sv */
// wideband lambda sensor control tick: sequencer, shared multiplier, config registers
// depends on wlct_pkg, wlct_stream_if, wlct_table, wlct_div and the macro header
//
// Each input transaction is either a calibration point write or a control tick
// with raw ADC samples, and each one gives exactly one result transaction with
// the pump duty, heater duty and lambda now in force. The block handles one
// transaction at a time: in_ch.ready is high only while the sequencer is idle,
// and a finished result sits in the output register so that the next input can
// be taken while it waits. A point write goes straight to the result; a tick
// whose current lies at or beyond the first or last point takes that point's
// lambda; a tick interpolated on segment k (1 to TABLE_POINTS - 1) scans the
// table up to point k and then runs the divider, and a tick whose current falls
// in no segment scans every point. The time a tick takes is set by the table
// search, one entry a cycle through the single read port, and by the 32-step
// restoring divider that forms the interpolation quotient. Configuration writes
// through cfg_we/cfg_index/cfg_wdata land at the next clock edge.
// Table entries hold no reset value; a tick must only meet written points.
`include "wideband_lambda_control_tick_macros.svh"

module wideband_lambda_control_tick (
  input  logic                              clk,
  input  logic                              rst_n,
  wlct_in_if.sink                           in_ch,
  wlct_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [wlct_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wlct_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import wlct_pkg::*;

  // configuration registers
  logic [11:0] nernst_tgt_r;
  logic [11:0] deadband_r;
  logic [11:0] heater_tgt_r;
  logic [15:0] gain_r;
  logic [7:0]  heater_intvl_r;

  // sequencer and architectural state
  state_t      state_r, state_nxt;
  logic [9:0]  pump_duty_r, pump_duty_nxt;
  logic [9:0]  heater_duty_r, heater_duty_nxt;
  logic [7:0]  tick_r, tick_nxt;
  logic [15:0] lambda_r, lambda_nxt;
  logic        eval_r, eval_nxt;
  logic        out_valid_r, out_valid_nxt;

  // latched samples and working registers
  logic [11:0]        vgnd_r, nernst_r, pump_r, pulse_lo_r, pulse_hi_r;
  logic signed [33:0] prod_r, prod_nxt;
  logic signed [15:0] c_r, c_nxt;
  tbl_entry_t         prev_r, prev_nxt;
  tbl_entry_t         seg0_r, seg0_nxt;
  tbl_entry_t         seg1_r, seg1_nxt;
  logic [TBL_AW-1:0]  k_r, k_nxt;
  logic               neg_r, neg_nxt;

  // output payload registers
  logic [9:0]  o_pump_r, o_heater_r;
  logic [15:0] o_lambda_r;
  logic        o_eval_r;

  logic in_accept;
  logic out_free;
  assign in_accept = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nernst_tgt_r   <= 12'd369;
      deadband_r     <= 12'd41;
      heater_tgt_r   <= 12'd200;
      gain_r         <= 16'd1880;
      heater_intvl_r <= 8'd20;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NERNST_TARGET: nernst_tgt_r   <= cfg_wdata[11:0];
        CFG_DEADBAND:      deadband_r     <= cfg_wdata[11:0];
        CFG_HEATER_TARGET: heater_tgt_r   <= cfg_wdata[11:0];
        CFG_CURRENT_GAIN:  gain_r         <= cfg_wdata[15:0];
        CFG_HEATER_INTVL:  heater_intvl_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // calibration table: written straight from the input channel on a point write
  // ---------------------------------------------------------------------------
  tbl_wr_t           tbl_wr;
  logic [TBL_AW-1:0] rd_addr;
  tbl_entry_t        rd_data;

  assign tbl_wr.we = in_accept && (in_ch.operation == OP_WRITE)
                     && (int'(in_ch.point_index) < TABLE_POINTS);
  assign tbl_wr.addr    = TBL_AW'(in_ch.point_index);
  assign tbl_wr.entry.x = in_ch.point_current;
  assign tbl_wr.entry.y = in_ch.point_lambda;

  wlct_table u_table (
    .clk     (clk),
    .wr      (tbl_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // ---------------------------------------------------------------------------
  // comparison terms for the pump and heater rules, all in adc counts
  // ---------------------------------------------------------------------------
  logic signed [13:0] nernst_d, pulse_d;
  logic signed [13:0] nt_lo, nt_hi, ht_lo, ht_hi;

  assign nernst_d = $signed({2'b00, nernst_r}) - $signed({2'b00, vgnd_r});
  assign pulse_d  = $signed({2'b00, pulse_hi_r}) - $signed({2'b00, pulse_lo_r});
  assign nt_lo    = $signed({2'b00, nernst_tgt_r}) - $signed({2'b00, deadband_r});
  assign nt_hi    = $signed({2'b00, nernst_tgt_r}) + $signed({2'b00, deadband_r});
  assign ht_lo    = $signed({2'b00, heater_tgt_r}) - $signed({2'b00, deadband_r});
  assign ht_hi    = $signed({2'b00, heater_tgt_r}) + $signed({2'b00, deadband_r});

  logic [7:0] tick_inc;
  assign tick_inc = tick_r + 8'd1;

  // ---------------------------------------------------------------------------
  // shared multiplier: current scaling on a tick, then the interpolation product
  // ---------------------------------------------------------------------------
  logic signed [17:0] mul_a, mul_b;
  logic signed [35:0] mul_p;
  logic signed [16:0] dx, dy;

  assign dx = $signed({c_r[15], c_r}) - $signed({seg0_r.x[15], seg0_r.x});
  assign dy = $signed({1'b0, seg1_r.y}) - $signed({1'b0, seg0_r.y});

  always_comb begin
    if (state_r == ST_MUL) begin
      mul_a = {dx[16], dx};
      mul_b = {dy[16], dy};
    end else begin
      mul_a = $signed({6'd0, pump_r}) - $signed({6'd0, vgnd_r});
      mul_b = $signed({2'b00, gain_r});
    end
  end

  assign mul_p = mul_a * mul_b;

  // floor of the product over 256, then saturate to q4.12 range
  logic signed [33:0] c_full;
  assign c_full = prod_r >>> 8;

  // ---------------------------------------------------------------------------
  // divider for the interpolation quotient
  // ---------------------------------------------------------------------------
  logic               div_start;
  logic [DIV_N_W-1:0] div_num;
  logic [DIV_D_W-1:0] div_den;
  logic [DIV_N_W-1:0] div_q;
  div_stat_t          div_st;
  logic signed [33:0] prod_neg;
  logic signed [16:0] seg_w;

  assign prod_neg  = -prod_r;
  assign seg_w     = $signed({seg1_r.x[15], seg1_r.x}) - $signed({seg0_r.x[15], seg0_r.x});
  assign div_start = (state_r == ST_DIVGO);
  assign div_num   = prod_r[33] ? prod_neg[DIV_N_W-1:0] : prod_r[DIV_N_W-1:0];
  assign div_den   = seg_w[DIV_D_W-1:0];

  wlct_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .stat     (div_st),
    .quotient (div_q)
  );

  // quotient magnitude never exceeds the lambda step of the segment
  logic signed [17:0] q_s;
  logic signed [18:0] y_sum;
  assign q_s   = neg_r ? -$signed({1'b0, div_q[16:0]}) : $signed({1'b0, div_q[16:0]});
  assign y_sum = $signed({3'b000, seg0_r.y}) + $signed({q_s[17], q_s});

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt       = state_r;
    pump_duty_nxt   = pump_duty_r;
    heater_duty_nxt = heater_duty_r;
    tick_nxt        = tick_r;
    lambda_nxt      = lambda_r;
    eval_nxt        = eval_r;
    out_valid_nxt   = out_valid_r;
    prod_nxt        = prod_r;
    c_nxt           = c_r;
    prev_nxt        = prev_r;
    seg0_nxt        = seg0_r;
    seg1_nxt        = seg1_r;
    k_nxt           = k_r;
    neg_nxt         = neg_r;
    rd_addr         = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          eval_nxt = 1'b0;
          if (in_ch.operation == OP_WRITE) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SCALE;
          end
        end
      end

      ST_SCALE: begin
        // pump bang-bang with deadband, otherwise hold
        if (nernst_d < nt_lo) begin
          pump_duty_nxt = PUMP_PUSH;
        end else if (nernst_d > nt_hi) begin
          pump_duty_nxt = PUMP_PULL;
        end
        // heater runs every heater_interval ticks
        if (tick_inc >= heater_intvl_r) begin
          tick_nxt = '0;
          eval_nxt = 1'b1;
          if (pulse_d > ht_hi) begin
            heater_duty_nxt = HEAT_ON;
          end else if (pulse_d < ht_lo) begin
            heater_duty_nxt = HEAT_OFF;
          end
        end else begin
          tick_nxt = tick_inc;
        end
        prod_nxt  = mul_p[33:0];
        state_nxt = ST_CLAMP;
      end

      ST_CLAMP: begin
        if (c_full > 34'sd32767) begin
          c_nxt = 16'sh7fff;
        end else if (c_full < -34'sd32768) begin
          c_nxt = 16'sh8000;
        end else begin
          c_nxt = c_full[15:0];
        end
        rd_addr   = '0;
        state_nxt = ST_LOW;
      end

      ST_LOW: begin
        // rd_data is the first point
        if (c_r <= rd_data.x) begin
          lambda_nxt = rd_data.y;
          state_nxt  = ST_DONE;
        end else begin
          prev_nxt  = rd_data;
          rd_addr   = TBL_AW'(TABLE_POINTS - 1);
          state_nxt = ST_HIGH;
        end
      end

      ST_HIGH: begin
        // rd_data is the last point
        if (c_r >= rd_data.x) begin
          lambda_nxt = rd_data.y;
          state_nxt  = ST_DONE;
        end else begin
          rd_addr   = TBL_AW'(1);
          k_nxt     = TBL_AW'(1);
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // rd_data is point k, prev_r is point k-1
        if ((prev_r.x <= c_r) && (c_r <= rd_data.x)) begin
          if (rd_data.x == prev_r.x) begin
            lambda_nxt = prev_r.y;
            state_nxt  = ST_DONE;
          end else begin
            seg0_nxt  = prev_r;
            seg1_nxt  = rd_data;
            state_nxt = ST_MUL;
          end
        end else if (k_r == TBL_AW'(TABLE_POINTS - 1)) begin
          // no segment holds the current
          lambda_nxt = LAMBDA_ONE;
          state_nxt  = ST_DONE;
        end else begin
          prev_nxt  = rd_data;
          k_nxt     = k_r + 1'b1;
          rd_addr   = k_r + 1'b1;
        end
      end

      ST_MUL: begin
        prod_nxt  = mul_p[33:0];
        state_nxt = ST_DIVGO;
      end

      ST_DIVGO: begin
        neg_nxt   = prod_r[33];
        state_nxt = ST_DIV;
      end

      ST_DIV: begin
        if (div_st.done) begin
          if (y_sum < 19'sd0) begin
            lambda_nxt = '0;
          end else if (y_sum > 19'sd65535) begin
            lambda_nxt = 16'hffff;
          end else begin
            lambda_nxt = y_sum[15:0];
          end
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      pump_duty_r   <= '0;
      heater_duty_r <= '0;
      tick_r        <= '0;
      lambda_r      <= LAMBDA_ONE;
      eval_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      pump_duty_r   <= pump_duty_nxt;
      heater_duty_r <= heater_duty_nxt;
      tick_r        <= tick_nxt;
      lambda_r      <= lambda_nxt;
      eval_r        <= eval_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload: samples latched on accept, working values, result register
  always_ff @(posedge clk) begin
    if (in_accept) begin
      vgnd_r     <= in_ch.vgnd_raw;
      nernst_r   <= in_ch.nernst_raw;
      pump_r     <= in_ch.pump_raw;
      pulse_lo_r <= in_ch.pulse_low_raw;
      pulse_hi_r <= in_ch.pulse_high_raw;
    end
    prod_r <= prod_nxt;
    c_r    <= c_nxt;
    prev_r <= prev_nxt;
    seg0_r <= seg0_nxt;
    seg1_r <= seg1_nxt;
    k_r    <= k_nxt;
    neg_r  <= neg_nxt;
    if ((state_r == ST_DONE) && out_free) begin
      o_pump_r   <= pump_duty_r;
      o_heater_r <= heater_duty_r;
      o_lambda_r <= lambda_r;
      o_eval_r   <= eval_r;
    end
  end

  assign in_ch.ready             = (state_r == ST_IDLE);
  assign out_ch.valid            = out_valid_r;
  assign out_ch.pump_duty        = o_pump_r;
  assign out_ch.heater_duty      = o_heater_r;
  assign out_ch.lambda_value     = o_lambda_r;
  assign out_ch.heater_evaluated = o_eval_r;

  // heater duty only moves on a tick that ran heater control
  `WLCT_ASSERT_IMP(a_heater_on_eval, clk, rst_n, heater_duty_r != $past(heater_duty_r), eval_r)
  // pump duty only ever holds one of its two drive values or the reset value
  `WLCT_ASSERT(a_pump_legal, clk, rst_n, pump_duty_r == '0 || pump_duty_r == PUMP_PUSH || pump_duty_r == PUMP_PULL)
  // the divider only runs while the sequencer waits on it
  `WLCT_ASSERT_IMP(a_div_in_state, clk, rst_n, div_st.busy || div_st.done, state_r == ST_DIV)
  // a new result only appears out of the finishing step
  `WLCT_ASSERT_IMP(a_result_from_done, clk, rst_n, $rose(out_valid_r), $past(state_r) == ST_DONE)

endmodule

/* hdl/wlct_table.sv */
// calibration table memory: one write port, one registered read port
// depends on wlct_pkg
module wlct_table (
  input  logic                              clk,
  input  wlct_pkg::tbl_wr_t                 wr,
  input  logic [wlct_pkg::TBL_AW-1:0]       rd_addr,
  output wlct_pkg::tbl_entry_t              rd_data
);
  import wlct_pkg::*;

  tbl_entry_t mem [TABLE_POINTS];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.entry;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* hdl/wlct_div.sv */
// restoring divider, one quotient bit per cycle, unsigned operands
// depends on wlct_pkg and the assertion macro header
`include "wideband_lambda_control_tick_macros.svh"

module wlct_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [wlct_pkg::DIV_N_W-1:0]   dividend,
  input  logic [wlct_pkg::DIV_D_W-1:0]   divisor,
  output wlct_pkg::div_stat_t            stat,
  output logic [wlct_pkg::DIV_N_W-1:0]   quotient
);
  import wlct_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_D_W-1:0]   rem_r, rem_nxt;
  logic [DIV_D_W-1:0]   den_r, den_nxt;
  logic [DIV_N_W-1:0]   quo_r, quo_nxt;
  logic [DIV_D_W:0]     rem_sh;
  logic [DIV_D_W+1:0]   trial;

  // shift in next dividend bit and try a subtract
  assign rem_sh = {rem_r, quo_r[DIV_N_W-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_N_W);
      rem_nxt  = '0;
      den_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      if (trial[DIV_D_W+1]) begin
        rem_nxt = rem_sh[DIV_D_W-1:0];
        quo_nxt = {quo_r[DIV_N_W-2:0], 1'b0};
      end else begin
        rem_nxt = trial[DIV_D_W-1:0];
        quo_nxt = {quo_r[DIV_N_W-2:0], 1'b1};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

  `WLCT_ASSERT_IMP(a_div_no_restart, clk, rst_n, start, !busy_r)
  `WLCT_ASSERT_IMP(a_div_cnt_live, clk, rst_n, busy_r, cnt_r != '0)

endmodule
